// File: src/assert_macros.svh
// Assertion helpers shared by the RTL; every check runs on clk and is off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge.
`define CLSR_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies another at the same edge.
`define CLSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another at the next edge.
`define CLSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/clsr_pkg.sv
package clsr_pkg;

  localparam int unsigned WORD_W          = 31;
  localparam int unsigned TABLE_DEPTH_DEF = 32;
  // Warm-up steps beyond the table depth before the table is loaded.
  localparam int unsigned WARM_EXTRA      = 8;

  typedef logic [WORD_W-1:0] word_t;

  // Moduli are 2^31 minus a small fold constant.
  localparam word_t       MOD_ONE   = 31'd2147483563;
  localparam word_t       MOD_TWO   = 31'd2147483399;
  localparam logic [15:0] MUL_ONE   = 16'd40014;
  localparam logic [15:0] MUL_TWO   = 16'd40692;
  localparam logic [7:0]  FOLD_ONE  = 8'd85;
  localparam logic [7:0]  FOLD_TWO  = 8'd249;
  localparam word_t       SEED_ONE  = 31'd1;
  localparam word_t       SEED_TWO  = 31'd123456789;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_WARM_MUL = 5'b00010,
    S_WARM_RED = 5'b00100,
    S_DRAW_RD  = 5'b01000,
    S_DRAW     = 5'b10000
  } state_t;

endpackage

// File: src/clsr_lcg_step.sv
module clsr_lcg_step import clsr_pkg::*; #(
  parameter logic [15:0] MUL  = MUL_ONE,
  parameter logic [7:0]  FOLD = FOLD_ONE
) (
  input  logic  clk,
  input  logic  load,
  input  word_t state_in,
  output word_t state_out
);

  localparam logic [31:0] MODULUS = 32'h8000_0000 - {24'd0, FOLD};

  logic [46:0] prod_r;
  logic [23:0] hi_scaled;
  logic [31:0] fold_sum;

  // Register the product of the multiplier and the current state.
  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= {31'd0, MUL} * {16'd0, state_in};
    end
  end

  // Fold the bits above 2^31 back in, since 2^31 is FOLD modulo the modulus.
  assign hi_scaled = {8'd0, prod_r[46:31]} * {16'd0, FOLD};
  assign fold_sum  = {1'b0, prod_r[30:0]} + {8'd0, hi_scaled};

  // The folded sum stays below twice the modulus: one subtract finishes it.
  always_comb begin
    if (fold_sum >= MODULUS) begin
      state_out = word_t'(fold_sum - MODULUS);
    end else begin
      state_out = fold_sum[30:0];
    end
  end

endmodule

// File: src/combined_lcg_shuffle_rng_top.sv
// Combined two-generator random source with a shuffle table. A draw item
// (action 0) reads the shuffle table memory and forms both generator products
// as it is accepted, then reduces them, combines with the table word and
// writes the slot back in S_DRAW. A reseed item (action 1) runs the warm-up
// steps of generator 1, each a multiply state (S_WARM_MUL) then a reduce state
// (S_WARM_RED), and then the draw through S_DRAW_RD and S_DRAW. Results sit
// in an output register backed by one skid entry, so an item is taken while an
// earlier result still waits. out_random_word is an integer in 1..2147483562;
// divide it by 2147483563 to get a deviate. The table comes out of reset as
// all zeros through per-slot valid flags, with no clearing pass.
`include "assert_macros.svh"

module combined_lcg_shuffle_rng_top import clsr_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  in_action,
  input  word_t in_seed_value,
  output logic  out_valid,
  input  logic  out_ready,
  output word_t out_random_word
);

  localparam int unsigned SLOT_W     = $clog2(TABLE_DEPTH);
  localparam int unsigned WARM_STEPS = TABLE_DEPTH + WARM_EXTRA;
  localparam int unsigned CNT_W      = $clog2(WARM_STEPS);
  localparam logic [31:0] SLOT_DIV   =
    32'd1 + (({1'b0, MOD_ONE} - 32'd1) / 32'(TABLE_DEPTH));
  localparam logic [31:0] WRAP_ADD   = {1'b0, MOD_ONE} - 32'd1;

  state_t             state_r;
  word_t              x_r;
  word_t              y_r;
  word_t              last_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [SLOT_W-1:0]  slot_sel;
  logic [CNT_W-1:0]   warm_slot;

  word_t              tbl_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tbl_vld_r;
  word_t              rd_data_r;
  logic               rd_vld_r;
  logic               tbl_we;
  logic               tbl_re;
  logic [SLOT_W-1:0]  tbl_waddr;

  word_t              x_new;
  word_t              y_new;
  word_t              tbl_word;
  word_t              seed_eff;
  word_t              draw_word;
  logic [31:0]        diff;
  logic [31:0]        diff_wrap;
  logic               g1_load;
  logic               g2_load;
  logic               in_fire;
  logic               res_valid;

  logic               out_valid_r;
  word_t              out_word_r;
  logic               skid_valid_r;
  word_t              skid_word_r;
  logic               out_free;

  assign in_ready        = (state_r == S_IDLE) && !skid_valid_r;
  assign in_fire         = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;
  assign seed_eff        = (in_seed_value == '0) ? SEED_ONE : in_seed_value;

  // Generator step units: registered multiply, then fold and reduce.
  assign g1_load = in_fire || (state_r == S_WARM_MUL) || (state_r == S_DRAW_RD);
  assign g2_load = in_fire || (state_r == S_DRAW_RD);

  clsr_lcg_step #(.MUL(MUL_ONE), .FOLD(FOLD_ONE)) u_gen_one (
    .clk       (clk),
    .load      (g1_load),
    .state_in  (x_r),
    .state_out (x_new)
  );

  clsr_lcg_step #(.MUL(MUL_TWO), .FOLD(FOLD_TWO)) u_gen_two (
    .clk       (clk),
    .load      (g2_load),
    .state_in  (y_r),
    .state_out (y_new)
  );

  // Pick the slot: highest threshold k*SLOT_DIV that the last output reaches.
  always_comb begin
    slot_sel = '0;
    for (int k = 1; k < TABLE_DEPTH; k++) begin
      if ({1'b0, last_r} >= 32'(k) * SLOT_DIV) begin
        slot_sel = SLOT_W'(k);
      end
    end
  end

  // Warm-up writes land from the top slot down to slot 0.
  assign warm_slot = CNT_W'(WARM_STEPS - 1) - cnt_r;

  assign tbl_re    = (in_fire && !in_action) || (state_r == S_DRAW_RD);
  assign tbl_we    = ((state_r == S_WARM_RED) && (cnt_r >= CNT_W'(WARM_EXTRA)))
                     || (state_r == S_DRAW);
  assign tbl_waddr = (state_r == S_DRAW) ? slot_r : warm_slot[SLOT_W-1:0];

  // Shuffle table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= x_new;
    end
    if (tbl_re) begin
      rd_data_r <= tbl_mem[slot_sel];
      slot_r    <= slot_sel;
    end
  end

  // Track written slots so the table reads as zeros after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (tbl_we) begin
        tbl_vld_r[tbl_waddr] <= 1'b1;
      end
      if (tbl_re) begin
        rd_vld_r <= tbl_vld_r[slot_sel];
      end
    end
  end

  // Combine the table word with generator 2 and wrap results below one.
  assign tbl_word  = rd_vld_r ? rd_data_r : '0;
  assign diff      = {1'b0, tbl_word} - {1'b0, y_new};
  assign diff_wrap = diff + WRAP_ADD;
  assign draw_word = (diff[31] || (diff == '0)) ? diff_wrap[30:0] : diff[30:0];
  assign res_valid = (state_r == S_DRAW);

  // Sequencer: a draw item goes straight to the draw; a reseed runs warm-up, then the draw.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      x_r     <= SEED_ONE;
      y_r     <= SEED_TWO;
      last_r  <= '0;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_action) begin
              x_r     <= seed_eff;
              y_r     <= seed_eff;
              cnt_r   <= '0;
              state_r <= S_WARM_MUL;
            end else begin
              state_r <= S_DRAW;
            end
          end
        end
        S_WARM_MUL: begin
          state_r <= S_WARM_RED;
        end
        S_WARM_RED: begin
          x_r   <= x_new;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(WARM_STEPS - 1)) begin
            last_r  <= x_new;
            state_r <= S_DRAW_RD;
          end else begin
            state_r <= S_WARM_MUL;
          end
        end
        S_DRAW_RD: begin
          state_r <= S_DRAW;
        end
        S_DRAW: begin
          x_r     <= x_new;
          y_r     <= y_new;
          last_r  <= draw_word;
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Output register with one skid entry behind it.
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= res_valid;
      end else begin
        out_valid_r  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_word_r  <= skid_word_r;
        skid_word_r <= draw_word;
      end else begin
        out_word_r  <= draw_word;
      end
    end else if (res_valid) begin
      skid_word_r <= draw_word;
    end
  end

  // Checks on sequencing and result delivery.
  `CLSR_ASSERT(a_skid_behind_out, !skid_valid_r || out_valid_r, "skid full with output empty")
  `CLSR_ASSERT_NXT(a_accept_next, in_fire, (state_r == S_DRAW) || (state_r == S_WARM_MUL), "accepted item did not start")
  `CLSR_ASSERT_NXT(a_draw_delivers, res_valid, out_valid_r && (last_r != '0), "draw result lost or zero")
  `CLSR_ASSERT_IMP(a_draw_after_read, res_valid, ($past(state_r) == S_IDLE) || ($past(state_r) == S_DRAW_RD), "draw without table read")

endmodule
